>>> hw/rtl/dbpg_pkg.sv
// Shared types, constants and band lookup for the distance beep pattern generator.
package dbpg_pkg;

    localparam int DIST_W   = 10;
    localparam int PERIOD_W = 5;
    localparam int PAUSE_W  = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W    = 14;
    localparam int REM_W    = PERIOD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_BASE  = 1'd1;

    localparam logic [CFG_W-1:0] BEEP_WINDOW_RST = 13'd995;
    localparam logic [CFG_W-1:0] CYCLE_BASE_RST  = 13'd1000;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PAUSE_W-1:0]  pause;
    } t_band;

    function automatic t_band band_of(input logic [DIST_W-1:0] d);
        t_band b;
        b.period = 5'd3;
        b.pause  = 13'd0;
        if (d <= 10'd400 && d > 10'd200) begin
            b.period = 5'd20; b.pause = 13'd6000;
        end else if (d <= 10'd200 && d > 10'd70) begin
            b.period = 5'd19; b.pause = 13'd5650;
        end else if (d <= 10'd70 && d > 10'd25) begin
            b.period = 5'd16; b.pause = 13'd4600;
        end else if (d <= 10'd25 && d > 10'd18) begin
            b.period = 5'd15; b.pause = 13'd4250;
        end else if (d <= 10'd18 && d > 10'd14) begin
            b.period = 5'd14; b.pause = 13'd3900;
        end else if (d <= 10'd14 && d > 10'd11) begin
            b.period = 5'd13; b.pause = 13'd3550;
        end else if (d <= 10'd11 && d > 10'd2) begin
            b.period = d[PERIOD_W-1:0] + 5'd1;
            case (d[3:0])
                4'd11:   b.pause = 13'd3200;
                4'd10:   b.pause = 13'd2850;
                4'd9:    b.pause = 13'd2500;
                4'd8:    b.pause = 13'd2150;
                4'd7:    b.pause = 13'd1800;
                4'd6:    b.pause = 13'd1450;
                4'd5:    b.pause = 13'd1100;
                4'd4:    b.pause = 13'd750;
                4'd3:    b.pause = 13'd400;
                default: b.pause = 13'd0;
            endcase
        end
        return b;
    endfunction

endpackage

>>> hw/rtl/distance_beep_pattern_generator_top.sv
// Top level of the distance beep pattern generator.
//
// Input channel: i_valid/o_ready with i_distance; every beat is one timer
// tick. Output channel: o_valid/i_ready with o_beep, o_tone_period and
// o_pause_extra; exactly one result beat per input beat, in order.
// Config channel: i_cfg_valid/o_cfg_ready, index 0 = beep window,
// index 1 = cycle base; always ready, write only while idle.
// The front end registers the band of each distance into a two-entry queue.
// The back end increments the tick counter and finds count mod period one
// bit per cycle, one item at a time: it takes the next band from the
// queue only once the result of the last one is registered.
// Reset clears the tick counter, queue and valids and loads the register
// defaults (995, 1000).
// A stalled receiver holds the result register; the back end finishes the
// next item and waits, then queue and front stage fill and o_ready drops.
module distance_beep_pattern_generator_top
    import dbpg_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DIST_W-1:0]    i_distance,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_beep,
    output logic [PERIOD_W-1:0]  o_tone_period,
    output logic [PAUSE_W-1:0]   o_pause_extra,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_beep_window;
    logic [CFG_W-1:0] r_cycle_base;

    logic  front_valid;
    logic  front_ready;
    t_band front_band;
    logic  q_valid;
    logic  q_ready;
    t_band q_band;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_window <= BEEP_WINDOW_RST;
            r_cycle_base  <= CYCLE_BASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BEEP_WINDOW: r_beep_window <= i_cfg_data;
                CFG_CYCLE_BASE:  r_cycle_base  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dbpg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_distance   (i_distance),
        .o_band_valid (front_valid),
        .i_band_ready (front_ready),
        .o_band       (front_band)
    );

    dbpg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_band  (front_band),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_band   (q_band)
    );

    dbpg_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_band_valid  (q_valid),
        .o_band_ready  (q_ready),
        .i_band        (q_band),
        .i_beep_window (r_beep_window),
        .i_cycle_base  (r_cycle_base),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_beep        (o_beep),
        .o_tone_period (o_tone_period),
        .o_pause_extra (o_pause_extra)
    );

endmodule

>>> hw/rtl/dbpg_front.sv
// Front end: accepts distance beats and registers the selected band.
module dbpg_front
    import dbpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DIST_W-1:0] i_distance,
    output logic              o_band_valid,
    input  logic              i_band_ready,
    output t_band             o_band
);

    logic  r_valid;
    t_band r_band;

    assign o_ready      = !r_valid || i_band_ready;
    assign o_band_valid = r_valid;
    assign o_band       = r_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_band <= band_of(i_distance);
        end
    end

endmodule

>>> hw/rtl/dbpg_queue.sv
// Two-entry band queue between front and back ends.
module dbpg_queue
    import dbpg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_band i_push_band,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_band o_pop_band
);

    t_band             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_band   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_band;
        end
    end

endmodule

>>> hw/rtl/dbpg_back.sv
// Back end: tick counter, bit-serial modulo by band period, result register.
module dbpg_back
    import dbpg_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_band_valid,
    output logic                o_band_ready,
    input  t_band               i_band,
    input  logic [CFG_W-1:0]    i_beep_window,
    input  logic [CFG_W-1:0]    i_cycle_base,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_beep,
    output logic [PERIOD_W-1:0] o_tone_period,
    output logic [PAUSE_W-1:0]  o_pause_extra
);

    localparam int IDX_W = $clog2(COUNT_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                r_state;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] r_new;
    logic [REM_W-1:0]      r_rem;
    logic [IDX_W-1:0]      r_idx;
    t_band                 r_band;
    logic                  r_out_valid;
    logic                  r_beep;
    logic [PERIOD_W-1:0]   r_tone_period;
    logic [PAUSE_W-1:0]    r_pause_extra;

    logic [REM_W:0]        rem_sh;
    logic [REM_W-1:0]      rem_nx;
    logic [SUM_W-1:0]      clr_at;
    logic                  beep;
    logic                  out_free;

    assign rem_sh   = {r_rem, r_new[r_idx]};
    assign rem_nx   = (rem_sh >= {1'b0, r_band.period})
                      ? REM_W'(rem_sh - {1'b0, r_band.period})
                      : rem_sh[REM_W-1:0];
    assign clr_at   = SUM_W'(i_cycle_base) + SUM_W'(r_band.pause);
    assign beep     = (r_rem == '0) && (r_new < COUNT_WIDTH'(i_beep_window));
    assign out_free = !r_out_valid || i_ready;

    assign o_band_ready  = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_beep        = r_beep;
    assign o_tone_period = r_tone_period;
    assign o_pause_extra = r_pause_extra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_band_valid) begin
                        r_new   <= r_cnt + 1'b1;
                        r_band  <= i_band;
                        r_rem   <= '0;
                        r_idx   <= IDX_W'(COUNT_WIDTH - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_nx;
                    if (r_idx == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_beep        <= beep;
                        r_tone_period <= r_band.period;
                        r_pause_extra <= r_band.pause;
                        if (!beep && r_new == COUNT_WIDTH'(clr_at)) begin
                            r_cnt <= '0;
                        end else begin
                            r_cnt <= r_new;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> tb/distance_beep_pattern_generator_top_test.sv
// Self-checking testbench for the distance beep pattern generator top level.
`timescale 1ns / 100ps

module distance_beep_pattern_generator_top_test;
    import dbpg_pkg::*;

    // narrowest counter the block supports
    localparam int CNT_W       = 14;
    localparam int SETTLE_CYC  = CNT_W + 8;
    localparam int PHASE_ITEMS = 360;
    localparam int DIR_N       = 28;

    typedef struct packed {
        logic                beep;
        logic [PERIOD_W-1:0] period;
        logic [PAUSE_W-1:0]  pause;
    } t_tone_result;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [DIST_W-1:0]    sample;
        logic                 typed;
        t_tone_result         want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [DIST_W-1:0]    i_distance = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_beep;
    logic [PERIOD_W-1:0]  o_tone_period;
    logic [PAUSE_W-1:0]   o_pause_extra;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic [CNT_W-1:0]  tick_cnt = '0;
    logic [CFG_W-1:0]  beep_win = BEEP_WINDOW_RST;
    logic [CFG_W-1:0]  cycle_len = CYCLE_BASE_RST;
    t_tone_result      pending_tones [$];
    int                fail_count = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                held_band = 0;

    int band_lo [17] = '{0, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 15, 19, 26, 71, 201, 401};
    int band_hi [17] = '{2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 14, 18, 25, 70, 200, 400, 1023};

    t_stim_row directed_rows [DIR_N] = '{
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd0,    1'b1, '{1'b0, 5'd3,  13'd0}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd1023, 1'b1, '{1'b0, 5'd3,  13'd0}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd400,  1'b1, '{1'b0, 5'd20, 13'd6000}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd401,  1'b1, '{1'b0, 5'd3,  13'd0}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd2,    1'b1, '{1'b0, 5'd3,  13'd0}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd3,    1'b1, '{1'b0, 5'd4,  13'd400}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd5,    1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd201,  1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd200,  1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd71,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd70,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd26,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd25,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd19,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd18,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd15,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd14,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd12,   1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd11,   1'b0, '0},
        // no beeps, counter clears at 20
        '{ROW_CFG,  CFG_BEEP_WINDOW, 13'd0,    10'd0, 1'b0, '0},
        '{ROW_CFG,  CFG_CYCLE_BASE,  13'd20,   10'd0, 1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd1023, 1'b1, '{1'b0, 5'd3, 13'd0}},
        // beep at 3 wins over the clear, counter runs past it
        '{ROW_CFG,  CFG_BEEP_WINDOW, 13'd8191, 10'd0, 1'b0, '0},
        '{ROW_CFG,  CFG_CYCLE_BASE,  13'd3,    10'd0, 1'b0, '0},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd0,    1'b1, '{1'b0, 5'd3, 13'd0}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd0,    1'b1, '{1'b0, 5'd3, 13'd0}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd0,    1'b1, '{1'b1, 5'd3, 13'd0}},
        '{ROW_TICK, CFG_BEEP_WINDOW, 13'd0, 10'd0,    1'b1, '{1'b0, 5'd3, 13'd0}}
    };

    distance_beep_pattern_generator_top #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_distance    (i_distance),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_beep        (o_beep),
        .o_tone_period (o_tone_period),
        .o_pause_extra (o_pause_extra),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_tone_result band_tone(input logic [DIST_W-1:0] d);
        t_tone_result r;
        r = '0;
        if (d <= 10'd2 || d > 10'd400) begin
            r.period = 5'd3;
            r.pause  = 13'd0;
        end else if (d > 10'd200) begin
            r.period = 5'd20;
            r.pause  = 13'd6000;
        end else if (d > 10'd70) begin
            r.period = 5'd19;
            r.pause  = 13'd5650;
        end else if (d > 10'd25) begin
            r.period = 5'd16;
            r.pause  = 13'd4600;
        end else if (d > 10'd18) begin
            r.period = 5'd15;
            r.pause  = 13'd4250;
        end else if (d > 10'd14) begin
            r.period = 5'd14;
            r.pause  = 13'd3900;
        end else if (d > 10'd11) begin
            r.period = 5'd13;
            r.pause  = 13'd3550;
        end else begin
            r.period = PERIOD_W'(int'(d) + 1);
            r.pause  = PAUSE_W'(350 * int'(d) - 650);
        end
        return r;
    endfunction

    function automatic t_tone_result advance_tick(input logic [DIST_W-1:0] d);
        t_tone_result r;
        r = band_tone(d);
        tick_cnt = tick_cnt + 1'b1;
        if (int'(tick_cnt) % int'(r.period) == 0 && int'(tick_cnt) < int'(beep_win)) begin
            r.beep = 1'b1;
        end else if (int'(tick_cnt) == int'(cycle_len) + int'(r.pause)) begin
            tick_cnt = '0;
        end
        return r;
    endfunction

    // mostly a held band with random content, some raw noise
    function automatic logic [DIST_W-1:0] next_distance();
        if ($urandom_range(99) < 10) return DIST_W'($urandom_range(1023));
        if ($urandom_range(39) == 0) held_band = $urandom_range(16);
        return DIST_W'($urandom_range(band_hi[held_band], band_lo[held_band]));
    endfunction

    task automatic wait_tones_drained();
        if (pending_tones.size() != 0) begin
            i_valid <= 1'b0;
            while (pending_tones.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic send_tick(input logic [DIST_W-1:0] d, input logic typed,
                             input t_tone_result want);
        t_tone_result calc;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_distance <= d;
        do @(posedge i_clk); while (!o_ready);
        calc = advance_tick(d);
        pending_tones.push_back(typed ? want : calc);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_tones_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BEEP_WINDOW) beep_win = val;
        else cycle_len = val;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : tone_check
        t_tone_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tones.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = pending_tones.pop_front();
                if (o_beep !== want.beep) begin
                    $error("beep: expected %0d, got %0d", want.beep, o_beep);
                    fail_count++;
                end
                if (o_tone_period !== want.period) begin
                    $error("tone_period: expected %0d, got %0d", want.period, o_tone_period);
                    fail_count++;
                end
                if (o_pause_extra !== want.pause) begin
                    $error("pause_extra: expected %0d, got %0d", want.pause, o_pause_extra);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                send_tick(directed_rows[r].sample, directed_rows[r].typed,
                          directed_rows[r].want);
            end
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    write_reg(CFG_BEEP_WINDOW, CFG_W'($urandom_range(8191)));
                    write_reg(CFG_CYCLE_BASE, CFG_W'($urandom_range(600)));
                end
                1: begin
                    idle_pct = 84; stall_pct = 0;
                    write_reg(CFG_BEEP_WINDOW, '1);
                    write_reg(CFG_CYCLE_BASE, '0);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 84;
                    write_reg(CFG_BEEP_WINDOW, '0);
                    write_reg(CFG_CYCLE_BASE, CFG_W'($urandom_range(2000)));
                end
                default: begin
                    idle_pct = 9;  stall_pct = 9;
                    write_reg(CFG_BEEP_WINDOW, CFG_W'($urandom_range(1200)));
                    write_reg(CFG_CYCLE_BASE, CFG_W'($urandom_range(300)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == PHASE_ITEMS / 2) wait_tones_drained();
                send_tick(next_distance(), 1'b0, '0);
            end
        end

        wait_tones_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/dbpg_pkg.sv
hw/rtl/dbpg_front.sv
hw/rtl/dbpg_queue.sv
hw/rtl/dbpg_back.sv
hw/rtl/distance_beep_pattern_generator_top.sv
tb/distance_beep_pattern_generator_top_test.sv
